[rtl/dlws_pkg.sv]
package dlws_pkg;

    // Fixed field widths of the beats
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CELL_W  = 5;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned COLOR_W = 32;

    // Default block configuration
    localparam int unsigned MAP_COLS_DEF  = 32;
    localparam int unsigned MAP_ROWS_DEF  = 32;
    localparam int unsigned TILE_SIZE_DEF = 50;
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Reciprocal scale for the divide-by-tile-size multiply; exact for
    // 12-bit coordinates and tile sizes up to 256
    localparam int unsigned TILE_SHIFT = 20;

    // Depth of the job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Command codes on the input beat
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_START,
        OP_ADVANCE,
        OP_NOP
    } dlws_op_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CELL_W-1:0]  cell_col;
        logic [CELL_W-1:0]  cell_row;
        logic               cell_is_wall;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] line_color;
    } dlws_in_t;

    typedef struct packed {
        logic               pixel_valid;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               line_done;
    } dlws_out_t;

    // Classified job handed from front to back
    typedef struct packed {
        dlws_op_t           op;
        logic               cell_ok;
        logic [CELL_W-1:0]  cell_col;
        logic [CELL_W-1:0]  cell_row;
        logic               cell_is_wall;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] abs_x;
        logic [COORD_W-1:0] abs_y;
        logic               neg_x;
        logic               neg_y;
        logic [COORD_W-1:0] steps;
        logic [COLOR_W-1:0] line_color;
    } dlws_job_t;

endpackage

[rtl/dlws_front.sv]
module dlws_front #(
    parameter int unsigned MAP_COLS = dlws_pkg::MAP_COLS_DEF,
    parameter int unsigned MAP_ROWS = dlws_pkg::MAP_ROWS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dlws_pkg::dlws_in_t  s_data,
    input  logic                clearing,
    output logic                job_valid,
    input  logic                job_pop,
    output dlws_pkg::dlws_job_t job
);

    localparam int unsigned PTR_W = (dlws_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(dlws_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(dlws_pkg::QUEUE_DEPTH + 1);
    localparam int unsigned CMP_W = dlws_pkg::CELL_W + 4;

    dlws_pkg::dlws_job_t q_reg [dlws_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    dlws_pkg::dlws_job_t     job_in;
    logic [dlws_pkg::COORD_W:0] dx;
    logic [dlws_pkg::COORD_W:0] dy;
    logic push;
    logic pull;

    // Classify the beat: decode the command, check the map cell,
    // and take line deltas apart into magnitude and sign
    always_comb begin
        dx = {1'b0, s_data.end_x} - {1'b0, s_data.start_x};
        dy = {1'b0, s_data.end_y} - {1'b0, s_data.start_y};

        job_in              = '0;
        job_in.cell_col     = s_data.cell_col;
        job_in.cell_row     = s_data.cell_row;
        job_in.cell_is_wall = s_data.cell_is_wall;
        job_in.start_x      = s_data.start_x;
        job_in.start_y      = s_data.start_y;
        job_in.line_color   = s_data.line_color;
        job_in.cell_ok      = (CMP_W'(s_data.cell_col) < CMP_W'(MAP_COLS)) &&
                              (CMP_W'(s_data.cell_row) < CMP_W'(MAP_ROWS));
        job_in.neg_x        = dx[dlws_pkg::COORD_W];
        job_in.neg_y        = dy[dlws_pkg::COORD_W];
        job_in.abs_x        = job_in.neg_x ? (s_data.start_x - s_data.end_x) :
                                             (s_data.end_x - s_data.start_x);
        job_in.abs_y        = job_in.neg_y ? (s_data.start_y - s_data.end_y) :
                                             (s_data.end_y - s_data.start_y);
        job_in.steps        = (job_in.abs_x > job_in.abs_y) ? job_in.abs_x : job_in.abs_y;

        case (s_data.cmd)
            dlws_pkg::CMD_WRITE:   job_in.op = dlws_pkg::OP_WRITE;
            dlws_pkg::CMD_START:   job_in.op = dlws_pkg::OP_START;
            dlws_pkg::CMD_ADVANCE: job_in.op = dlws_pkg::OP_ADVANCE;
            default:               job_in.op = dlws_pkg::OP_NOP;
        endcase
    end

    assign s_ready   = (count_reg != CNT_W'(dlws_pkg::QUEUE_DEPTH)) && !clearing;
    assign push      = s_valid && s_ready;
    assign job_valid = (count_reg != '0);
    assign pull      = job_valid && job_pop;
    assign job       = q_reg[rd_ptr_reg];

    // Queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(dlws_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pull) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(dlws_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pull) begin
                count_reg <= count_reg + 1'b1;
            end else if (pull && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

[rtl/dlws_div.sv]
module dlws_div #(
    parameter int unsigned NUM_W = dlws_pkg::COORD_W + dlws_pkg::FRAC_BITS_DEF,
    parameter int unsigned DEN_W = dlws_pkg::COORD_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic             fits;

    // One restoring step: bring down the next dividend bit, try a subtract
    always_comb begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        fits    = !diff[DEN_W+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(NUM_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/dlws_back.sv]
module dlws_back #(
    parameter int unsigned MAP_COLS  = dlws_pkg::MAP_COLS_DEF,
    parameter int unsigned MAP_ROWS  = dlws_pkg::MAP_ROWS_DEF,
    parameter int unsigned TILE_SIZE = dlws_pkg::TILE_SIZE_DEF,
    parameter int unsigned FRAC_BITS = dlws_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_pop,
    input  dlws_pkg::dlws_job_t job,
    output logic                clearing,
    output logic                m_valid,
    input  logic                m_ready,
    output dlws_pkg::dlws_out_t m_data
);

    localparam int unsigned COORD_W    = dlws_pkg::COORD_W;
    localparam int unsigned MAP_DEPTH  = MAP_COLS * MAP_ROWS;
    localparam int unsigned ADDR_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int unsigned POS_W      = COORD_W + FRAC_BITS;
    localparam int unsigned INC_W      = FRAC_BITS + 2;
    localparam int unsigned RECIP_W    = dlws_pkg::TILE_SHIFT + 1;
    localparam int unsigned PROD_W     = COORD_W + RECIP_W;
    localparam int unsigned TILE_RECIP =
        ((2 ** dlws_pkg::TILE_SHIFT) + TILE_SIZE - 1) / TILE_SIZE;

    // Result beat with no pixel and the line ended
    localparam dlws_pkg::dlws_out_t END_BEAT = '{
        pixel_valid: 1'b0,
        pixel_x:     '0,
        pixel_y:     '0,
        pixel_color: '0,
        line_done:   1'b1
    };

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_LOOK
    } state_t;

    state_t state_reg;

    // Wall map and its ports
    logic                  wall_mem [MAP_DEPTH];
    logic                  rd_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic                  mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [ADDR_W-1:0]     clr_addr_reg;

    // Line state
    logic [POS_W-1:0]         pos_x_reg;
    logic [POS_W-1:0]         pos_y_reg;
    logic signed [INC_W-1:0]  incr_x_reg;
    logic signed [INC_W-1:0]  incr_y_reg;
    logic [COORD_W-1:0]       steps_left_reg;
    logic [dlws_pkg::COLOR_W-1:0] held_color_reg;
    logic                     line_active_reg;
    logic                     neg_x_reg;
    logic                     neg_y_reg;

    // Tile lookup pipeline
    logic [PROD_W-1:0]  prod_x_reg;
    logic [PROD_W-1:0]  prod_y_reg;
    logic               in_map_reg;

    // Result register
    logic                m_valid_reg;
    dlws_pkg::dlws_out_t m_data_reg;

    logic                 out_free;
    logic                 m_load;
    logic                 div_start;
    logic                 div_x_done;
    logic                 div_y_done;
    logic [POS_W-1:0]     quo_x;
    logic [POS_W-1:0]     quo_y;
    logic signed [INC_W-1:0] mag_x;
    logic signed [INC_W-1:0] mag_y;
    logic [COORD_W-1:0]   pix_x;
    logic [COORD_W-1:0]   pix_y;
    logic [COORD_W-1:0]   tile_col;
    logic [COORD_W-1:0]   tile_row;
    logic                 tile_in_map;
    logic [POS_W-1:0]     step_x;
    logic [POS_W-1:0]     step_y;

    assign out_free  = !m_valid_reg || m_ready;
    assign job_pop   = (state_reg == ST_IDLE) && job_valid && out_free;
    assign div_start = job_pop && (job.op == dlws_pkg::OP_START) && (job.steps != '0);
    assign clearing  = (state_reg == ST_CLEAR);

    assign pix_x    = pos_x_reg[POS_W-1:FRAC_BITS];
    assign pix_y    = pos_y_reg[POS_W-1:FRAC_BITS];
    assign tile_col = prod_x_reg[dlws_pkg::TILE_SHIFT +: COORD_W];
    assign tile_row = prod_y_reg[dlws_pkg::TILE_SHIFT +: COORD_W];
    assign tile_in_map = (tile_col < COORD_W'(MAP_COLS)) && (tile_row < COORD_W'(MAP_ROWS));

    assign mag_x  = INC_W'(quo_x[FRAC_BITS:0]);
    assign mag_y  = INC_W'(quo_y[FRAC_BITS:0]);
    assign step_x = POS_W'(incr_x_reg);
    assign step_y = POS_W'(incr_y_reg);

    // Increments: |delta| << FRAC_BITS over the step count
    dlws_div #(
        .NUM_W (POS_W),
        .DEN_W (COORD_W)
    ) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({job.abs_x, {FRAC_BITS{1'b0}}}),
        .divisor  (job.steps),
        .done     (div_x_done),
        .quotient (quo_x)
    );

    dlws_div #(
        .NUM_W (POS_W),
        .DEN_W (COORD_W)
    ) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({job.abs_y, {FRAC_BITS{1'b0}}}),
        .divisor  (job.steps),
        .done     (div_y_done),
        .quotient (quo_y)
    );

    // Map port selection: clearing sweep, cell writes, tile reads
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = 1'b0;
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (job_pop && (job.op == dlws_pkg::OP_WRITE) && job.cell_ok) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(ADDR_W'(job.cell_row) * ADDR_W'(MAP_COLS)) +
                        ADDR_W'(job.cell_col);
            mem_wdata = job.cell_is_wall;
        end
        mem_raddr = tile_in_map ?
                    ADDR_W'(ADDR_W'(tile_row) * ADDR_W'(MAP_COLS)) + ADDR_W'(tile_col) :
                    '0;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wall_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= wall_mem[mem_raddr];
    end

    // Result beat loads: immediate jobs, divider finish, tile lookup finish
    always_comb begin
        case (state_reg)
            ST_IDLE: m_load = job_pop && !div_start &&
                              !((job.op == dlws_pkg::OP_ADVANCE) && line_active_reg &&
                                (steps_left_reg != '0));
            ST_DIV:  m_load = div_x_done && div_y_done;
            ST_LOOK: m_load = 1'b1;
            default: m_load = 1'b0;
        endcase
    end

    // Result valid: set on load, cleared when the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Sequencer, line state and result data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            line_active_reg <= 1'b0;
            steps_left_reg  <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(MAP_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (job_pop) begin
                        case (job.op)
                            dlws_pkg::OP_START: begin
                                pos_x_reg      <= {job.start_x, {FRAC_BITS{1'b0}}};
                                pos_y_reg      <= {job.start_y, {FRAC_BITS{1'b0}}};
                                steps_left_reg <= job.steps;
                                held_color_reg <= job.line_color;
                                neg_x_reg      <= job.neg_x;
                                neg_y_reg      <= job.neg_y;
                                if (job.steps == '0) begin
                                    // zero-length line ends at once
                                    incr_x_reg      <= '0;
                                    incr_y_reg      <= '0;
                                    line_active_reg <= 1'b0;
                                    m_data_reg      <= END_BEAT;
                                end else begin
                                    state_reg <= ST_DIV;
                                end
                            end

                            dlws_pkg::OP_ADVANCE: begin
                                if (!line_active_reg || (steps_left_reg == '0)) begin
                                    line_active_reg <= 1'b0;
                                    m_data_reg      <= END_BEAT;
                                end else begin
                                    // tile = pixel / TILE_SIZE by reciprocal multiply
                                    prod_x_reg <= PROD_W'(pix_x) * PROD_W'(TILE_RECIP);
                                    prod_y_reg <= PROD_W'(pix_y) * PROD_W'(TILE_RECIP);
                                    state_reg  <= ST_ADDR;
                                end
                            end

                            default: begin
                                // map writes and unused commands: no pixel
                                m_data_reg <= '{
                                    pixel_valid: 1'b0,
                                    pixel_x:     '0,
                                    pixel_y:     '0,
                                    pixel_color: '0,
                                    line_done:   !line_active_reg
                                };
                            end
                        endcase
                    end
                end

                ST_DIV: begin
                    if (div_x_done && div_y_done) begin
                        incr_x_reg      <= neg_x_reg ? -mag_x : mag_x;
                        incr_y_reg      <= neg_y_reg ? -mag_y : mag_y;
                        line_active_reg <= 1'b1;
                        m_data_reg      <= '0;
                        state_reg       <= ST_IDLE;
                    end
                end

                ST_ADDR: begin
                    in_map_reg <= tile_in_map;
                    state_reg  <= ST_LOOK;
                end

                ST_LOOK: begin
                    state_reg <= ST_IDLE;
                    if (!in_map_reg || rd_reg) begin
                        // wall or off-map tile ends the line
                        line_active_reg <= 1'b0;
                        m_data_reg      <= END_BEAT;
                    end else begin
                        m_data_reg.pixel_valid <= 1'b1;
                        m_data_reg.pixel_x     <= pix_x;
                        m_data_reg.pixel_y     <= pix_y;
                        m_data_reg.pixel_color <= held_color_reg;
                        m_data_reg.line_done   <= (steps_left_reg == COORD_W'(1));
                        pos_x_reg       <= pos_x_reg + step_x;
                        pos_y_reg       <= pos_y_reg + step_y;
                        steps_left_reg  <= steps_left_reg - 1'b1;
                        line_active_reg <= (steps_left_reg != COORD_W'(1));
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/dda_line_with_wall_stop.sv]
// DDA line rasterizer with wall stop.
// Input channel s_: one beat per command. A write beat sets one cell of the
// wall map, a start beat loads a line (endpoints and color), an advance beat
// steps the active line by one pixel. Output channel m_: exactly one result
// beat per input beat, in order, carrying an optional pixel and line_done.
// Input beats go through a two-entry job queue into the execution engine.
// Write and unused beats load the result register when taken from the queue;
// advance beats pass through multiply, map address and map read; a start beat
// with a nonzero length waits on the bit-serial increment dividers (one
// quotient bit per cycle). Sustained rate: one write beat per cycle while
// the receiver takes results; an advance beat holds the engine until its map
// read is done. Reset: the wall map is swept clear, one cell per cycle;
// s_ready stays low until the sweep is done. No line is active.
// When the receiver stalls, the result register holds its beat and the queue
// keeps taking input beats until it is full.
module dda_line_with_wall_stop #(
    parameter int unsigned MAP_COLS  = dlws_pkg::MAP_COLS_DEF,
    parameter int unsigned MAP_ROWS  = dlws_pkg::MAP_ROWS_DEF,
    parameter int unsigned TILE_SIZE = dlws_pkg::TILE_SIZE_DEF,
    parameter int unsigned FRAC_BITS = dlws_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dlws_pkg::dlws_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dlws_pkg::dlws_out_t m_data
);

    logic                clearing;
    logic                job_valid;
    logic                job_pop;
    dlws_pkg::dlws_job_t job;

    // Front: accept, classify, queue
    dlws_front #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .clearing  (clearing),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    // Back: wall map, line stepping, result register
    dlws_back #(
        .MAP_COLS  (MAP_COLS),
        .MAP_ROWS  (MAP_ROWS),
        .TILE_SIZE (TILE_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .clearing  (clearing),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
